// ----- src/ffha_pkg.sv -----
// Shared constants, codes and types of the first-fit heap allocator.
// No dependencies; every other file imports this package.
`default_nettype none
package ffha_pkg;
  localparam int ARENA_BYTES  = 65536;
  localparam int HEADER_BYTES = 16;
  localparam int ALIGN_BYTES  = 16;

  localparam int FIELD_W   = 16;
  localparam int POS_W     = $clog2(ARENA_BYTES) + 1;
  localparam int SIZE_W    = POS_W - 1;
  localparam int HDR_DEPTH = ARENA_BYTES / HEADER_BYTES;
  localparam int IDX_W     = $clog2(HDR_DEPTH);
  localparam int HDR_SHIFT = $clog2(HEADER_BYTES);
  localparam int PROD_W    = 2 * FIELD_W;

  localparam logic [POS_W-1:0] HDR_POS   = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] ARENA_POS = POS_W'(ARENA_BYTES);
  localparam logic [POS_W-1:0] MAX_SIZE  = POS_W'(ARENA_BYTES - HEADER_BYTES);

  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_ZALLOC = 2'd1,
    KIND_FREE   = 2'd2,
    KIND_RESIZE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_ZERO  = 2'd2
  } status_t;

  typedef struct packed {
    logic              free;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  localparam hdr_t RESET_HDR = '{free: 1'b1, size: MAX_SIZE[SIZE_W-1:0]};
endpackage
`default_nettype wire

// ----- src/ffha_if.sv -----
// Request and response channel interfaces of the heap allocator.
// Depends on ffha_pkg for the field widths.
`default_nettype none
interface ffha_req_if;
  import ffha_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [FIELD_W-1:0] request_bytes;
  logic [FIELD_W-1:0] count;
  logic [FIELD_W-1:0] block_address;
  modport source (output valid, kind, request_bytes, count, block_address, input ready);
  modport sink (input valid, kind, request_bytes, count, block_address, output ready);
endinterface

interface ffha_rsp_if;
  import ffha_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [FIELD_W-1:0] address;
  logic [FIELD_W-1:0] copy_from;
  logic [FIELD_W-1:0] copy_bytes;
  logic [FIELD_W-1:0] zero_bytes;
  modport source (output valid, status, address, copy_from, copy_bytes, zero_bytes,
                  input ready);
  modport sink (input valid, status, address, copy_from, copy_bytes, zero_bytes,
                output ready);
endinterface
`default_nettype wire

// ----- src/ffha_hdr_mem.sv -----
// Block header memory, one entry per header-sized slot, indexed by block start.
// Registered read with write-first forwarding; entry 0 reads as the whole-arena block until written.
`default_nettype none
module ffha_hdr_mem (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [ffha_pkg::IDX_W-1:0] wr_idx,
  input  wire ffha_pkg::hdr_t        wr_data,
  input  wire logic [ffha_pkg::IDX_W-1:0] rd_idx,
  output ffha_pkg::hdr_t             rd_data
);
  import ffha_pkg::*;

  hdr_t mem [HDR_DEPTH];
  hdr_t q;
  logic q_zero;
  logic init0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    q      <= (wr_en && wr_idx == rd_idx) ? wr_data : mem[rd_idx];
    q_zero <= (rd_idx == '0);
  end

  // entry 0 holds the single free block after reset until it is first written
  always_ff @(posedge clk) begin
    if (rst) begin
      init0 <= 1'b1;
    end else if (wr_en && wr_idx == '0) begin
      init0 <= 1'b0;
    end
  end

  assign rd_data = (init0 && q_zero) ? RESET_HDR : q;
endmodule
`default_nettype wire

// ----- src/first_fit_heap_allocator.sv -----
// First-fit heap allocator over a header memory walked one block per cycle.
// A registered request walks one step per header visited (plus an end check on a miss);
// a zeroed allocate first forms its product and a split writes the tail header; a free releases
// and merges; a moving resize walks twice (locate, then first fit), then releases and merges.
// Throughput: one transaction at a time; the next is taken once the result is queued.
// Reset: synchronous; the arena becomes one free block and no clearing pass is needed.
// Depends on ffha_pkg, ffha_if and ffha_hdr_mem.
`default_nettype none
module first_fit_heap_allocator (
  input wire logic clk,
  input wire logic rst,
  ffha_req_if.sink req,
  ffha_rsp_if.source rsp
);
  import ffha_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL   = 8'b0000_0010,
    S_LOC   = 8'b0000_0100,
    S_WALK  = 8'b0000_1000,
    S_SPLIT = 8'b0001_0000,
    S_REL   = 8'b0010_0000,
    S_MRG   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  kind_t              kind_q, kind_next;
  logic [FIELD_W-1:0] req_q, req_next, cnt_q, cnt_next, baddr_q, baddr_next;
  logic [POS_W-1:0]   need, need_next;
  logic [POS_W-1:0]   cur, cur_next;
  logic [POS_W-1:0]   old_s, old_s_next, tail_s, tail_s_next;
  logic [SIZE_W-1:0]  old_size, old_size_next, tail_size, tail_size_next;
  status_t            st_q, st_next;
  logic [FIELD_W-1:0] addr_q, addr_next, cfrom_q, cfrom_next;
  logic [FIELD_W-1:0] cbytes_q, cbytes_next, zbytes_q, zbytes_next;

  logic               out_valid;
  status_t            out_status;
  logic [FIELD_W-1:0] out_addr, out_cfrom, out_cbytes, out_zbytes;
  logic               load;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  hdr_t               wr_data;
  hdr_t               hdr;

  logic [POS_W-1:0]   hdr_size, blk_end, user_pos, rnd, split_lim;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W:0]    prod_rnd;
  logic               at_end, fits, do_split, moving;

  ffha_hdr_mem u_mem (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (wr_en),
    .wr_idx (wr_idx),
    .wr_data(wr_data),
    .rd_idx (cur_next[HDR_SHIFT +: IDX_W]),
    .rd_data(hdr)
  );

  assign hdr_size  = {1'b0, hdr.size};
  assign blk_end   = cur + HDR_POS + hdr_size;
  assign user_pos  = cur + HDR_POS;
  assign at_end    = (cur == ARENA_POS);
  assign fits      = hdr.free && (hdr_size >= need);
  assign split_lim = need + HDR_POS;
  assign do_split  = hdr_size > split_lim;
  assign moving    = (kind_q == KIND_RESIZE) && (baddr_q != '0);
  assign rnd = ({1'b0, req.request_bytes} + POS_W'(ALIGN_BYTES - 1))
               & ~POS_W'(ALIGN_BYTES - 1);
  assign prod     = PROD_W'(req_q) * PROD_W'(cnt_q);
  assign prod_rnd = ({1'b0, prod} + (PROD_W + 1)'(ALIGN_BYTES - 1))
                    & ~(PROD_W + 1)'(ALIGN_BYTES - 1);

  assign req.ready = (state == S_IDLE);
  assign load      = (state == S_FIN) && (!out_valid || rsp.ready);

  always_comb begin
    state_next     = state;
    kind_next      = kind_q;
    req_next       = req_q;
    cnt_next       = cnt_q;
    baddr_next     = baddr_q;
    need_next      = need;
    cur_next       = cur;
    old_s_next     = old_s;
    old_size_next  = old_size;
    tail_s_next    = tail_s;
    tail_size_next = tail_size;
    st_next        = st_q;
    addr_next      = addr_q;
    cfrom_next     = cfrom_q;
    cbytes_next    = cbytes_q;
    zbytes_next    = zbytes_q;
    wr_en          = 1'b0;
    wr_idx         = cur[HDR_SHIFT +: IDX_W];
    wr_data        = hdr;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          kind_next   = kind_t'(req.kind);
          req_next    = req.request_bytes;
          cnt_next    = req.count;
          baddr_next  = req.block_address;
          need_next   = rnd;
          cur_next    = '0;
          st_next     = ST_OK;
          addr_next   = '0;
          cfrom_next  = '0;
          cbytes_next = '0;
          zbytes_next = '0;
          priority if (req.kind == KIND_ALLOC || (req.kind == KIND_RESIZE
                       && req.request_bytes != '0 && req.block_address == '0)) begin
            if (req.request_bytes == '0) begin
              st_next    = ST_ZERO;
              state_next = S_FIN;
            end else if (rnd > MAX_SIZE) begin
              st_next    = ST_NOFIT;
              state_next = S_FIN;
            end else begin
              state_next = S_WALK;
            end
          end else if (req.kind == KIND_ZALLOC) begin
            state_next = S_MUL;
          end else if (req.kind == KIND_FREE || req.request_bytes == '0) begin
            if (req.kind == KIND_RESIZE) st_next = ST_ZERO;
            state_next = ({1'b0, req.block_address} < HDR_POS) ? S_FIN : S_LOC;
          end else begin
            if ({1'b0, req.block_address} < HDR_POS) begin
              st_next    = ST_NOFIT;
              state_next = S_FIN;
            end else begin
              state_next = S_LOC;
            end
          end
        end
      end
      S_MUL: begin
        need_next = prod_rnd[POS_W-1:0];
        if (prod == '0) begin
          st_next    = ST_ZERO;
          state_next = S_FIN;
        end else if (prod_rnd > (PROD_W + 1)'(MAX_SIZE)) begin
          st_next    = ST_NOFIT;
          state_next = S_FIN;
        end else begin
          state_next = S_WALK;
        end
      end
      S_LOC: begin
        priority if (at_end || user_pos > {1'b0, baddr_q}) begin
          if (kind_q == KIND_RESIZE && req_q != '0) st_next = ST_NOFIT;
          state_next = S_FIN;
        end else if (user_pos == {1'b0, baddr_q}) begin
          old_s_next    = cur;
          old_size_next = hdr.size;
          priority if (kind_q == KIND_FREE || req_q == '0) begin
            state_next = S_REL;
          end else if (hdr_size >= need) begin
            addr_next  = baddr_q;
            state_next = S_FIN;
          end else if (need > MAX_SIZE) begin
            st_next    = ST_NOFIT;
            state_next = S_FIN;
          end else begin
            cur_next   = '0;
            state_next = S_WALK;
          end
        end else begin
          cur_next = blk_end;
        end
      end
      S_WALK: begin
        priority if (at_end) begin
          st_next    = ST_NOFIT;
          state_next = S_FIN;
        end else if (fits) begin
          wr_en        = 1'b1;
          wr_data.free = 1'b0;
          wr_data.size = do_split ? need[SIZE_W-1:0] : hdr.size;
          addr_next    = user_pos[FIELD_W-1:0];
          if (kind_q == KIND_ZALLOC) zbytes_next = need[FIELD_W-1:0];
          if (moving) begin
            cfrom_next  = baddr_q;
            cbytes_next = old_size[FIELD_W-1:0];
          end
          tail_s_next    = split_lim + cur;
          tail_size_next = SIZE_W'(hdr_size - split_lim);
          priority if (do_split) state_next = S_SPLIT;
          else if (moving)       state_next = S_REL;
          else                   state_next = S_FIN;
        end else begin
          cur_next = blk_end;
        end
      end
      S_SPLIT: begin
        wr_en        = 1'b1;
        wr_idx       = tail_s[HDR_SHIFT +: IDX_W];
        wr_data.free = 1'b1;
        wr_data.size = tail_size;
        state_next   = moving ? S_REL : S_FIN;
      end
      S_REL: begin
        wr_en        = 1'b1;
        wr_idx       = old_s[HDR_SHIFT +: IDX_W];
        wr_data.free = 1'b1;
        wr_data.size = old_size;
        cur_next     = old_s + HDR_POS + {1'b0, old_size};
        state_next   = S_MRG;
      end
      S_MRG: begin
        // absorb the following block when it is free
        if (!at_end && hdr.free) begin
          wr_en        = 1'b1;
          wr_idx       = old_s[HDR_SHIFT +: IDX_W];
          wr_data.free = 1'b1;
          wr_data.size = SIZE_W'({1'b0, old_size} + hdr_size + HDR_POS);
        end
        state_next = S_FIN;
      end
      S_FIN: begin
        if (load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_q    <= kind_next;
    req_q     <= req_next;
    cnt_q     <= cnt_next;
    baddr_q   <= baddr_next;
    need      <= need_next;
    cur       <= cur_next;
    old_s     <= old_s_next;
    old_size  <= old_size_next;
    tail_s    <= tail_s_next;
    tail_size <= tail_size_next;
    st_q      <= st_next;
    addr_q    <= addr_next;
    cfrom_q   <= cfrom_next;
    cbytes_q  <= cbytes_next;
    zbytes_q  <= zbytes_next;
    if (load) begin
      out_status <= st_q;
      out_addr   <= addr_q;
      out_cfrom  <= cfrom_q;
      out_cbytes <= cbytes_q;
      out_zbytes <= zbytes_q;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.address    = out_addr;
  assign rsp.copy_from  = out_cfrom;
  assign rsp.copy_bytes = out_cbytes;
  assign rsp.zero_bytes = out_zbytes;

`ifndef SYNTHESIS
  a_cur_in_arena: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> cur <= ARENA_POS) else $error("walk position beyond arena");
  a_tail_sane: assert property (@(posedge clk) disable iff (rst)
    state == S_SPLIT |-> tail_size != '0 && tail_s < ARENA_POS)
    else $error("split tail empty or outside arena");
  a_ok_addr: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_OK && rsp.address != '0
    |-> {1'b0, rsp.address} >= HDR_POS) else $error("user address inside first header");
  a_copy_src: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.copy_bytes != '0 |-> rsp.copy_from != '0 && rsp.status == ST_OK)
    else $error("copy reported without source");
  a_merge_after_rel: assert property (@(posedge clk) disable iff (rst)
    state == S_MRG |-> $past(state) == S_REL) else $error("merge without release");
`endif
endmodule
`default_nettype wire

// ----- dv/tb_first_fit_heap_allocator.sv -----
// Testbench for the first-fit heap allocator: directed and random requests,
// a block-list predictor in a scoreboard class, and a check of every result.
// Depends on ffha_pkg, ffha_if and the allocator RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  typedef struct {
    int unsigned start;
    int unsigned size;
    bit          is_free;
  } heap_block_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] address;
    logic [15:0] copy_from;
    logic [15:0] copy_bytes;
    logic [15:0] zero_bytes;
  } alloc_result_t;

  class alloc_scoreboard;
    heap_block_t   blocks[$];
    alloc_result_t pending[$];
    int            errors;
    int            checked;
    int            moves;
    int            nofits;
    int            max_blocks;

    function new();
      heap_block_t b;
      b.start = 0;
      b.size = ARENA_BYTES - HEADER_BYTES;
      b.is_free = 1;
      blocks.push_back(b);
      max_blocks = 1;
    endfunction

    function longint unsigned align_up(longint unsigned n);
      return ((n + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    endfunction

    function int find_block(longint unsigned ua);
      if (ua < HEADER_BYTES) return -1;
      foreach (blocks[i]) begin
        if (blocks[i].start + HEADER_BYTES == ua) return i;
        if (blocks[i].start + HEADER_BYTES > ua) return -1;
      end
      return -1;
    endfunction

    function bit first_fit(longint unsigned need, output longint unsigned ua);
      heap_block_t tail;
      ua = 0;
      foreach (blocks[i]) begin
        if (blocks[i].is_free && blocks[i].size >= need) begin
          if (blocks[i].size > need + HEADER_BYTES) begin
            tail.start = blocks[i].start + HEADER_BYTES + need;
            tail.size = blocks[i].size - need - HEADER_BYTES;
            tail.is_free = 1;
            blocks.insert(i + 1, tail);
            blocks[i].size = need;
          end
          blocks[i].is_free = 0;
          ua = blocks[i].start + HEADER_BYTES;
          if (blocks.size() > max_blocks) max_blocks = blocks.size();
          return 1;
        end
      end
      return 0;
    endfunction

    function void release_block(int idx);
      if (idx < 0 || idx >= blocks.size()) return;
      blocks[idx].is_free = 1;
      if (idx + 1 < blocks.size() && blocks[idx + 1].is_free) begin
        blocks[idx].size += blocks[idx + 1].size + HEADER_BYTES;
        blocks.delete(idx + 1);
      end
    endfunction

    // Predict one transaction and queue its result.
    function void note_request(kind_t k, logic [15:0] req, logic [15:0] cnt,
                               logic [15:0] ba);
      alloc_result_t r;
      longint unsigned got, need, total, old_size;
      int idx;
      r = '0;
      r.status = ST_OK;
      if (k == KIND_ALLOC || (k == KIND_RESIZE && req != 0 && ba == 0)) begin
        if (req == 0) r.status = ST_ZERO;
        else if (first_fit(align_up(req), got)) r.address = got[15:0];
        else r.status = ST_NOFIT;
      end else if (k == KIND_ZALLOC) begin
        total = longint'(req) * longint'(cnt);
        if (total == 0) r.status = ST_ZERO;
        else begin
          need = align_up(total);
          if (first_fit(need, got)) begin
            r.address = got[15:0];
            r.zero_bytes = need[15:0];
          end else r.status = ST_NOFIT;
        end
      end else if (k == KIND_FREE) begin
        if (ba != 0) release_block(find_block(ba));
      end else if (req == 0) begin
        if (ba != 0) release_block(find_block(ba));
        r.status = ST_ZERO;
      end else begin
        idx = find_block(ba);
        if (idx < 0) r.status = ST_NOFIT;
        else begin
          old_size = blocks[idx].size;
          need = align_up(req);
          if (old_size >= need) r.address = ba;
          else if (first_fit(need, got)) begin
            r.address = got[15:0];
            r.copy_from = ba;
            r.copy_bytes = old_size[15:0];
            release_block(find_block(ba));
            moves++;
          end else r.status = ST_NOFIT;
        end
      end
      if (r.status == ST_NOFIT) nofits++;
      pending.push_back(r);
    endfunction

    function void check_result(alloc_result_t act);
      alloc_result_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, act);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.status !== act.status)
        $display("%0t: status exp %0d act %0d", $time, e.status, act.status);
      if (e.address !== act.address)
        $display("%0t: address exp %h act %h", $time, e.address, act.address);
      if (e.copy_from !== act.copy_from)
        $display("%0t: copy_from exp %h act %h", $time, e.copy_from, act.copy_from);
      if (e.copy_bytes !== act.copy_bytes)
        $display("%0t: copy_bytes exp %h act %h", $time, e.copy_bytes, act.copy_bytes);
      if (e.zero_bytes !== act.zero_bytes)
        $display("%0t: zero_bytes exp %h act %h", $time, e.zero_bytes, act.zero_bytes);
      if (e !== act) errors++;
    endfunction

    // Pick a user address: mostly that of a listed block, free or in use, sometimes a bad one.
    function logic [15:0] pick_address();
      int r;
      r = $urandom_range(99);
      if (r < 80) return 16'(blocks[$urandom_range(blocks.size() - 1)].start
                             + HEADER_BYTES);
      if (r < 88) return 16'h0;
      return 16'($urandom);
    endfunction
  endclass

  logic clk;
  logic rst;
  ffha_req_if req_ch();
  ffha_rsp_if rsp_ch();
  alloc_scoreboard heap_sb;
  bit stall_free;

  first_fit_heap_allocator dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function int gap_len();
    if ($urandom_range(9) < 6) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3);
    return $urandom_range(40);
  endfunction

  // Drop valid only for a real gap; back to back, the next transaction replaces it.
  task automatic send(kind_t k, logic [15:0] rb, logic [15:0] cn, logic [15:0] ba);
    int g;
    g = stall_free ? 0 : gap_len();
    if (g != 0) begin
      req_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind <= k;
    req_ch.request_bytes <= rb;
    req_ch.count <= cn;
    req_ch.block_address <= ba;
    do @(posedge clk); while (!req_ch.ready);
    heap_sb.note_request(k, rb, cn, ba);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (heap_sb.pending.size() != 0) @(posedge clk);
  endtask

  // Response side: random backpressure, checked at each accepting edge.
  initial begin
    int g;
    rsp_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      g = stall_free ? 0 : gap_len();
      if (g != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do begin
        @(posedge clk);
        if (rsp_ch.valid)
          heap_sb.check_result({rsp_ch.status, rsp_ch.address, rsp_ch.copy_from,
                                rsp_ch.copy_bytes, rsp_ch.zero_bytes});
      end while (!rsp_ch.valid);
    end
  end

  initial begin
    #200ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int n, r;
    logic [15:0] a, b;
    heap_sb = new();
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.kind = KIND_ALLOC;
    req_ch.request_bytes = '0;
    req_ch.count = '0;
    req_ch.block_address = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes and each special case.
    send(KIND_ALLOC, 16'd0, 16'hFFFF, 16'hFFFF);
    send(KIND_ALLOC, 16'd1, 16'd0, 16'd0);
    send(KIND_ALLOC, 16'hFFFF, 16'd0, 16'd0);
    send(KIND_ZALLOC, 16'd0, 16'd5, 16'd0);
    send(KIND_ZALLOC, 16'hFFFF, 16'hFFFF, 16'd0);
    send(KIND_ZALLOC, 16'd3, 16'd7, 16'd0);
    send(KIND_FREE, 16'd0, 16'd0, 16'd0);
    send(KIND_FREE, 16'd0, 16'd0, 16'd17);
    send(KIND_RESIZE, 16'd40, 16'd0, 16'd0);
    send(KIND_RESIZE, 16'd8, 16'd0, 16'd16);
    send(KIND_RESIZE, 16'd200, 16'd0, 16'd16);
    send(KIND_RESIZE, 16'd8, 16'd0, 16'd18);
    send(KIND_FREE, 16'd0, 16'd0, 16'd48);
    send(KIND_FREE, 16'd0, 16'd0, 16'd48);
    send(KIND_RESIZE, 16'd16, 16'd0, 16'd48);
    send(KIND_RESIZE, 16'd0, 16'd0, 16'd48);
    send(KIND_RESIZE, 16'hFFF0, 16'd0, 16'd80);
    send(KIND_ALLOC, 16'd65520, 16'd0, 16'd0);
    send(KIND_RESIZE, 16'd0, 16'hFFFF, 16'd0);
    // Hold off until the block has answered everything.
    drain();

    n = 0;
    while (n < 750) begin
      stall_free = (n >= 300 && n < 380);
      if (n == 500) drain();
      r = $urandom_range(99);
      b = heap_sb.pick_address();
      if (r < 35) begin
        a = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(1, 600));
        send(KIND_ALLOC, a, 16'($urandom), 16'($urandom));
      end else if (r < 45) begin
        if ($urandom_range(9) == 0) send(KIND_ZALLOC, 16'($urandom), 16'($urandom), b);
        else send(KIND_ZALLOC, 16'($urandom_range(0, 40)), 16'($urandom_range(0, 20)), b);
      end else if (r < 75) begin
        send(KIND_FREE, 16'($urandom), 16'($urandom), b);
      end else begin
        a = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 800));
        send(KIND_RESIZE, a, 16'($urandom), b);
      end
      n++;
    end
    stall_free = 0;
    drain();
    repeat (200) @(posedge clk);
    $display("Checked %0d results: %0d moving resizes, %0d no-fit, peak %0d blocks.",
             heap_sb.checked, heap_sb.moves, heap_sb.nofits, heap_sb.max_blocks);
    if (heap_sb.errors == 0 && heap_sb.pending.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
